[design/led_pmc_pkg.sv]
// ----------------------------------------------------------------------------
// led_pmc_pkg
// Shared codes and command-word tables for the LED pattern mode controller.
// ----------------------------------------------------------------------------
package led_pmc_pkg;

   // item kinds carried in req_tuser
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PRESS = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;

   // pattern modes
   localparam logic [2:0] MODE_ALL_ON  = 3'd0;
   localparam logic [2:0] MODE_ALL_OFF = 3'd1;
   localparam logic [2:0] MODE_UP      = 3'd2;
   localparam logic [2:0] MODE_DOWN    = 3'd3;
   localparam logic [2:0] MODE_BLOOM   = 3'd4;
   localparam logic [2:0] MODE_WILT    = 3'd5;

   // line terminators
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // command words, one per mode 0..3, padded with NUL
   localparam int          WORD_COUNT = 4;
   localparam int          WORD_MAX   = 12;
   localparam logic [0:WORD_COUNT-1][0:WORD_MAX-1][7:0] CMD_WORDS = '{
      '{"l", "e", "d", "_", "a", "l", "l", "_", "o", "n", 8'h00, 8'h00},
      '{"l", "e", "d", "_", "a", "l", "l", "_", "o", "f", "f", 8'h00},
      '{"l", "e", "d", "_", "u", "p", "_", "o", "n", 8'h00, 8'h00, 8'h00},
      '{"l", "e", "d", "_", "d", "o", "w", "n", "_", "o", "n", 8'h00}
   };
   localparam logic [0:WORD_COUNT-1][3:0] CMD_LENGTHS = '{4'd10, 4'd11, 4'd9, 4'd11};

   // base patterns for the walking and flower modes
   localparam logic [7:0] WALK_UP_BASE    = 8'h01;
   localparam logic [7:0] WALK_DOWN_BASE  = 8'h80;
   localparam logic [7:0] FLOWER_HI_BASE  = 8'h10;
   localparam logic [7:0] FLOWER_LO_BASE  = 8'h08;
   localparam logic [15:0] PERIOD_RESET   = 16'd100;
   localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

endpackage

[design/led_pattern_mode_controller.sv]
// ----------------------------------------------------------------------------
// led_pattern_mode_controller
// Eight-LED pattern generator; mode set by button presses or serial commands.
// ----------------------------------------------------------------------------
//
// channel  | direction | transfer contents
// ---------+-----------+--------------------------------------------------
// req_     | in        | tuser: item kind, tdata: received serial byte
// rsp_     | out       | tdata: led_pattern, mode_valid, mode
// csr_     | in        | step_period write, always accepted
//
// One item every cycle while rsp is not stalled. A req transfer loads the input
// register, then the state update from the input register loads the result
// register. A stalled rsp holds the result and the input register, req_tready
// stays high while the input register can drain. Reset is synchronous and
// restores every mode, position, counter and line state.
//
module led_pattern_mode_controller
   import led_pmc_pkg::*;
#(
   parameter int LINE_CAPACITY = 50
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] led_pattern, [8] mode_valid, [11:9] mode
   // step period register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

   // input register
   logic             in_valid_ff;
   logic [1:0]       in_op_ff;
   logic [7:0]       in_byte_ff;
   // result register valid
   logic             rsp_valid_ff;
   // configuration
   logic [15:0]      step_period_ff;
   // controller state
   logic             mode_sel_ff,    mode_sel_in;
   logic [2:0]       mode_ff,        mode_in;
   logic [7:0]       led_ff,         led_in;
   logic [2:0]       walk_up_pos_ff, walk_up_pos_in;
   logic [2:0]       walk_dn_pos_ff, walk_dn_pos_in;
   logic [1:0]       bloom_pos_ff,   bloom_pos_in;
   logic [1:0]       wilt_pos_ff,    wilt_pos_in;
   logic [15:0]      walk_ticks_ff,  walk_ticks_in;
   logic [15:0]      flower_ticks_ff, flower_ticks_in;
   logic [LEN_W-1:0] line_len_ff,    line_len_in;
   logic [3:0]       cmd_match_ff,   cmd_match_in;
   logic             line_cut_ff,    line_cut_in;

   logic             advance;
   logic [3:0]       hit;
   logic [3:0]       len_eq;
   logic [1:0]       wilt_k;

   // handshake: input register drains into the result register
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, mode_ff, mode_sel_ff, led_ff};
   assign wilt_k     = 2'd3 - wilt_pos_ff;

   // command lengths equal to the current line length
   always_comb begin
      for (int w = 0; w < WORD_COUNT; w++) begin
         len_eq[w] = (line_len_ff == LEN_W'(CMD_LENGTHS[w]));
      end
   end

   // next state for one item: event first, then the pattern step
   always_comb begin
      mode_sel_in     = mode_sel_ff;
      mode_in         = mode_ff;
      led_in          = led_ff;
      walk_up_pos_in  = walk_up_pos_ff;
      walk_dn_pos_in  = walk_dn_pos_ff;
      bloom_pos_in    = bloom_pos_ff;
      wilt_pos_in     = wilt_pos_ff;
      walk_ticks_in   = walk_ticks_ff;
      flower_ticks_in = flower_ticks_ff;
      line_len_in     = line_len_ff;
      cmd_match_in    = cmd_match_ff;
      line_cut_in     = line_cut_ff;
      hit             = cmd_match_ff;

      case (in_op_ff)
         OP_TICK: begin
            if (walk_ticks_ff != TICKS_MAX) walk_ticks_in = walk_ticks_ff + 16'd1;
            if (flower_ticks_ff != TICKS_MAX) flower_ticks_in = flower_ticks_ff + 16'd1;
         end
         OP_PRESS: begin
            mode_sel_in = 1'b1;
            if (!mode_sel_ff || mode_ff >= MODE_WILT) mode_in = MODE_ALL_ON;
            else mode_in = mode_ff + 3'd1;
         end
         OP_BYTE: begin
            if (in_byte_ff == CHAR_LF || in_byte_ff == CHAR_CR) begin
               // end of line: first surviving word picks the mode
               if (!line_cut_ff) hit = cmd_match_ff & len_eq;
               if (hit[0]) begin
                  mode_in = MODE_ALL_ON;  mode_sel_in = 1'b1;
               end else if (hit[1]) begin
                  mode_in = MODE_ALL_OFF; mode_sel_in = 1'b1;
               end else if (hit[2]) begin
                  mode_in = MODE_UP;      mode_sel_in = 1'b1;
               end else if (hit[3]) begin
                  mode_in = MODE_DOWN;    mode_sel_in = 1'b1;
               end
               line_len_in  = '0;
               cmd_match_in = 4'hF;
               line_cut_in  = 1'b0;
            end else if (line_len_ff < LEN_LIMIT) begin
               // characters beyond the first LINE_CAPACITY - 1 of a line are dropped
               if (!line_cut_ff) begin
                  if (in_byte_ff == CHAR_NUL) begin
                     cmd_match_in = cmd_match_ff & len_eq;
                     line_cut_in  = 1'b1;
                  end else begin
                     for (int w = 0; w < WORD_COUNT; w++) begin
                        if (!(line_len_ff < LEN_W'(CMD_LENGTHS[w]) &&
                              CMD_WORDS[w][line_len_ff[3:0]] == in_byte_ff)) begin
                           cmd_match_in[w] = 1'b0;
                        end
                     end
                  end
               end
               line_len_in = line_len_ff + 1'b1;
            end
         end
         default: ;
      endcase

      // pattern step for the current mode
      if (mode_sel_in) begin
         case (mode_in)
            MODE_ALL_ON:  led_in = 8'hFF;
            MODE_ALL_OFF: led_in = 8'h00;
            MODE_UP: begin
               if (walk_ticks_in >= step_period_ff) begin
                  walk_ticks_in  = '0;
                  led_in         = WALK_UP_BASE << walk_up_pos_ff;
                  walk_up_pos_in = walk_up_pos_ff + 3'd1;
               end
            end
            MODE_DOWN: begin
               if (walk_ticks_in >= step_period_ff) begin
                  walk_ticks_in  = '0;
                  led_in         = WALK_DOWN_BASE >> walk_dn_pos_ff;
                  walk_dn_pos_in = walk_dn_pos_ff + 3'd1;
               end
            end
            MODE_BLOOM: begin
               if (flower_ticks_in >= step_period_ff) begin
                  flower_ticks_in = '0;
                  led_in          = (FLOWER_HI_BASE << bloom_pos_ff) |
                                    (FLOWER_LO_BASE >> bloom_pos_ff);
                  bloom_pos_in    = bloom_pos_ff + 2'd1;
               end
            end
            MODE_WILT: begin
               if (flower_ticks_in >= step_period_ff) begin
                  flower_ticks_in = '0;
                  led_in          = ~((FLOWER_HI_BASE << wilt_k) |
                                      (FLOWER_LO_BASE >> wilt_k));
                  wilt_pos_in     = wilt_pos_ff + 2'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // control, configuration and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         step_period_ff  <= PERIOD_RESET;
         mode_sel_ff     <= 1'b0;
         mode_ff         <= MODE_ALL_ON;
         led_ff          <= 8'h00;
         walk_up_pos_ff  <= '0;
         walk_dn_pos_ff  <= '0;
         bloom_pos_ff    <= '0;
         wilt_pos_ff     <= '0;
         walk_ticks_ff   <= '0;
         flower_ticks_ff <= '0;
         line_len_ff     <= '0;
         cmd_match_ff    <= 4'hF;
         line_cut_ff     <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_valid) step_period_ff <= csr_data;
         if (advance) begin
            mode_sel_ff     <= mode_sel_in;
            mode_ff         <= mode_in;
            led_ff          <= led_in;
            walk_up_pos_ff  <= walk_up_pos_in;
            walk_dn_pos_ff  <= walk_dn_pos_in;
            bloom_pos_ff    <= bloom_pos_in;
            wilt_pos_ff     <= wilt_pos_in;
            walk_ticks_ff   <= walk_ticks_in;
            flower_ticks_ff <= flower_ticks_in;
            line_len_ff     <= line_len_in;
            cmd_match_ff    <= cmd_match_in;
            line_cut_ff     <= line_cut_in;
         end
      end
   end

endmodule

[test/tb_led_pattern_mode_controller.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_pattern_mode_controller
// Self-checking bench: a directed table, then random ticks, presses and serial
// command lines. Each transfer is run through an in-bench copy of the mode,
// pattern and line-matching logic, and the predicted LED word, valid bit and
// mode, or a typed table row, are compared against every response in order.
// ----------------------------------------------------------------------------
module tb_led_pattern_mode_controller;
   import led_pmc_pkg::*;

   localparam int         LINE_CAPACITY  = 50;
   localparam logic [1:0] OP_NONE        = 2'd3;
   localparam int         IDLE_LIMIT     = 5000;
   localparam int         DRAIN_CYCLES   = 6;
   localparam int         WIDE_TICKS     = 40;
   localparam int         DIRECTED_COUNT = 28;
   localparam int         REPORT_MAX     = 10;

   typedef struct packed {
      logic [7:0] led;
      logic       valid;
      logic [2:0] mode;
   } led_result_type;

   typedef struct packed {
      logic [1:0]     op;
      logic [7:0]     ch;
      logic           typed;
      led_result_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic [1:0]  req_tuser;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;   // [7:0] led_pattern, [8] mode_valid, [11:9] mode
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // predicted controller state
   logic [15:0] period_now;
   logic        mode_chosen;
   logic [2:0]  mode_now;
   logic [7:0]  led_now;
   logic [2:0]  up_step;
   logic [2:0]  down_step;
   logic [1:0]  bloom_step;
   logic [1:0]  wilt_step;
   logic [15:0] walk_count;
   logic [15:0] flower_count;
   int          line_fill;
   logic [3:0]  word_hits;
   logic        line_cut;

   led_result_type pending_leds [$];
   led_result_type want_res;
   led_result_type got_res;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          items_sent;
   int          results_seen;
   int          lines_sent;
   int          fault_count;
   int          quiet_cycles;

   // directed table: typed results only where they are obvious
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{OP_TICK,  8'h00,    1'b1, '{8'h00, 1'b0, MODE_ALL_ON}},
      '{OP_NONE,  8'hFF,    1'b1, '{8'h00, 1'b0, MODE_ALL_ON}},
      '{OP_BYTE,  "x",      1'b1, '{8'h00, 1'b0, MODE_ALL_ON}},
      '{OP_BYTE,  CHAR_LF,  1'b1, '{8'h00, 1'b0, MODE_ALL_ON}},
      '{OP_PRESS, 8'h00,    1'b1, '{8'hFF, 1'b1, MODE_ALL_ON}},
      '{OP_PRESS, 8'hFF,    1'b1, '{8'h00, 1'b1, MODE_ALL_OFF}},
      '{OP_PRESS, 8'hFF,    1'b0, '0},
      '{OP_TICK,  8'h55,    1'b0, '0},
      '{OP_PRESS, 8'hAA,    1'b0, '0},
      '{OP_TICK,  8'h00,    1'b0, '0},
      '{OP_PRESS, 8'h00,    1'b0, '0},
      '{OP_TICK,  8'h00,    1'b0, '0},
      '{OP_PRESS, 8'h00,    1'b0, '0},
      '{OP_TICK,  8'h00,    1'b0, '0},
      '{OP_PRESS, 8'h00,    1'b1, '{8'hFF, 1'b1, MODE_ALL_ON}},
      '{OP_BYTE,  CHAR_CR,  1'b1, '{8'hFF, 1'b1, MODE_ALL_ON}},
      '{OP_BYTE,  "l",      1'b0, '0},
      '{OP_BYTE,  "e",      1'b0, '0},
      '{OP_BYTE,  "d",      1'b0, '0},
      '{OP_BYTE,  "_",      1'b0, '0},
      '{OP_BYTE,  "u",      1'b0, '0},
      '{OP_BYTE,  "p",      1'b0, '0},
      '{OP_BYTE,  "_",      1'b0, '0},
      '{OP_BYTE,  "o",      1'b0, '0},
      '{OP_BYTE,  "n",      1'b0, '0},
      '{OP_BYTE,  CHAR_NUL, 1'b0, '0},
      '{OP_BYTE,  "z",      1'b0, '0},
      '{OP_BYTE,  CHAR_LF,  1'b0, '0}
   };

   led_pattern_mode_controller #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // advance the predicted state by one item and return the LED word
   task automatic step_led_controller(input logic [1:0] op, input logic [7:0] ch,
                                      output led_result_type res);
      logic [3:0] hit;
      logic       found;
      logic [1:0] k;
      case (op)
         OP_TICK: begin
            if (walk_count != 16'hFFFF) walk_count = walk_count + 16'd1;
            if (flower_count != 16'hFFFF) flower_count = flower_count + 16'd1;
         end
         OP_PRESS: begin
            if (!mode_chosen) begin
               mode_now    = MODE_ALL_ON;
               mode_chosen = 1'b1;
            end else begin
               mode_now = (mode_now >= MODE_WILT) ? MODE_ALL_ON : mode_now + 3'd1;
            end
         end
         OP_BYTE: begin
            if (ch == CHAR_LF || ch == CHAR_CR) begin
               // end of line: only words of the exact length survive
               hit = word_hits;
               if (!line_cut)
                  for (int w = 0; w < 4; w++)
                     if (int'(CMD_LENGTHS[w]) != line_fill) hit[w] = 1'b0;
               found = 1'b0;
               for (int w = 0; w < 4; w++)
                  if (hit[w] && !found) begin
                     mode_now    = w[2:0];
                     mode_chosen = 1'b1;
                     found       = 1'b1;
                  end
               line_fill = 0;
               word_hits = 4'hF;
               line_cut  = 1'b0;
            end else if (line_fill < LINE_CAPACITY - 1) begin
               if (!line_cut) begin
                  if (ch == CHAR_NUL) begin
                     // nul freezes the match at the current length
                     for (int w = 0; w < 4; w++)
                        if (int'(CMD_LENGTHS[w]) != line_fill) word_hits[w] = 1'b0;
                     line_cut = 1'b1;
                  end else begin
                     for (int w = 0; w < 4; w++)
                        if (!(line_fill < int'(CMD_LENGTHS[w]) &&
                              CMD_WORDS[w][line_fill] == ch))
                           word_hits[w] = 1'b0;
                  end
               end
               line_fill++;
            end
         end
         default: ;
      endcase

      // pattern logic, once a mode exists
      if (mode_chosen) begin
         case (mode_now)
            MODE_ALL_ON:  led_now = 8'hFF;
            MODE_ALL_OFF: led_now = 8'h00;
            MODE_UP: begin
               if (walk_count >= period_now) begin
                  walk_count = '0;
                  led_now    = 8'h01 << up_step;
                  up_step    = up_step + 3'd1;
               end
            end
            MODE_DOWN: begin
               if (walk_count >= period_now) begin
                  walk_count = '0;
                  led_now    = 8'h80 >> down_step;
                  down_step  = down_step + 3'd1;
               end
            end
            MODE_BLOOM: begin
               if (flower_count >= period_now) begin
                  flower_count = '0;
                  led_now      = (8'h10 << bloom_step) | (8'h08 >> bloom_step);
                  bloom_step   = bloom_step + 2'd1;
               end
            end
            MODE_WILT: begin
               if (flower_count >= period_now) begin
                  flower_count = '0;
                  k            = 2'd3 - wilt_step;
                  led_now      = ~((8'h10 << k) | (8'h08 >> k));
                  wilt_step    = wilt_step + 2'd1;
               end
            end
            default: ;
         endcase
      end
      res = '{led_now, mode_chosen, mode_now};
   endtask

   // one req transfer, with random sender gaps
   task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                            input logic typed = 1'b0, input led_result_type want = '0);
      led_result_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = ch;
      do @(posedge clock); while (!req_tready);
      step_led_controller(op, ch, res);
      pending_leds.push_back(typed ? want : res);
      items_sent++;
   endtask

   // hold off until every expected response has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_leds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      period_now = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_text_char();
      logic [7:0] ch;
      ch = 8'($urandom_range(255));
      if (ch == CHAR_LF || ch == CHAR_CR) ch = ch + 8'd1;
      return ch;
   endfunction

   // serial character, sometimes with a tick slipped in ahead of it
   task automatic send_line_char(input logic [7:0] ch);
      if ($urandom_range(9) < 3) send_item(OP_TICK, 8'($urandom_range(255)));
      send_item(OP_BYTE, ch);
   endtask

   // command word line; variants 0-5 clean, 6 corrupt char, 7 nul then junk,
   // 8 nul inside the word, 9 trailing junk
   task automatic send_command_line(input int w, input int variant);
      int wlen;
      int spot;
      wlen = int'(CMD_LENGTHS[w]);
      spot = $urandom_range(wlen - 1);
      for (int i = 0; i < wlen; i++) begin
         if (variant == 6 && i == spot) send_line_char(pick_text_char());
         else if (variant == 8 && i == spot) send_line_char(CHAR_NUL);
         else send_line_char(CMD_WORDS[w][i]);
      end
      if (variant == 7) send_line_char(CHAR_NUL);
      if (variant == 7 || variant == 9)
         repeat ($urandom_range(1, 5)) send_line_char(pick_text_char());
      send_line_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
      lines_sent++;
   endtask

   task automatic send_random_burst();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         send_item(OP_TICK, 8'($urandom_range(255)));
      end else if (pick < 50) begin
         send_item(OP_PRESS, 8'($urandom_range(255)));
      end else if (pick < 75) begin
         send_command_line($urandom_range(3), $urandom_range(9));
      end else if (pick < 80) begin
         // long line, any tail beyond capacity is dropped
         repeat ($urandom_range(45, 70)) send_item(OP_BYTE, pick_text_char());
         send_item(OP_BYTE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
      end else if (pick < 85) begin
         send_item(OP_NONE, 8'($urandom_range(255)));
      end else begin
         send_item(OP_BYTE, 8'($urandom_range(255)));
      end
   endtask

   task automatic run_random_phase(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) send_random_burst();
   endtask

   // random receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got_res = '{rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[11:9]};
         if (pending_leds.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected response transfer: led %h valid %b mode %0d",
                        got_res.led, got_res.valid, got_res.mode);
         end else begin
            want_res = pending_leds.pop_front();
            if (got_res.led != want_res.led || got_res.valid != want_res.valid ||
                got_res.mode != want_res.mode) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("response %0d exp/got: led %h/%h valid %b/%b mode %0d/%0d",
                           results_seen, want_res.led, got_res.led, want_res.valid,
                           got_res.valid, want_res.mode, got_res.mode);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = OP_TICK;
      req_tdata    = 8'h00;
      csr_valid    = 1'b0;
      csr_data     = 16'h0000;
      quiet_cycles = 0;
      items_sent   = 0;
      results_seen = 0;
      lines_sent   = 0;
      fault_count  = 0;
      period_now   = 16'd100;
      mode_chosen  = 1'b0;
      mode_now     = MODE_ALL_ON;
      led_now      = 8'h00;
      up_step      = '0;
      down_step    = '0;
      bloom_step   = '0;
      wilt_step    = '0;
      walk_count   = '0;
      flower_count = '0;
      line_fill    = 0;
      word_hits    = 4'hF;
      line_cut     = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 79;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table at the shortest nonzero period
      write_period(16'd1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].typed,
                   directed_rows[i].want);

      // zero period: patterns step on every item
      write_period(16'd0);
      run_random_phase(300);

      send_idle_pct = 79;
      recv_idle_pct = 23;
      write_period(16'd3);
      run_random_phase(300);

      // no idling; pause mid-phase until the pipe is empty
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_period(16'd2);
      run_random_phase(150);
      drain_results();
      run_random_phase(150);

      // widest period, no pattern step within these ticks
      write_period(16'hFFFF);
      send_command_line(0, 0);
      repeat (WIDE_TICKS) send_item(OP_TICK, 8'($urandom_range(255)));
      send_command_line(3, 0);
      send_item(OP_PRESS, 8'h00);
      repeat (4) send_item(OP_TICK, 8'h00);

      write_period(16'd7);
      run_random_phase(200);

      drain_results();
      if (pending_leds.size() != 0) fault_count++;
      $display("run: %0d request transfers, %0d command lines, %0d responses checked",
               items_sent, lines_sent, results_seen);
      $display("periods 0 to 65535; all modes, nul, long and bad lines, stalls both sides");
      if (fault_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
